>>> hw/rtl/quadrature_encoder_accumulator_defines.svh
// ----------------------------------------------------------------------------
// Quadrature encoder accumulator - assertion macros
// Clocked assertion wrappers. Define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_ACCUMULATOR_DEFINES_SVH
`define QUADRATURE_ENCODER_ACCUMULATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property at every rising edge, skipped while reset is low.
`define QEA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("qea assertion failed");
// Check a property at every rising edge, reset included.
`define QEA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("qea assertion failed");
`else
`define QEA_ASSERT(label, clk, rst_n, prop)
`define QEA_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> hw/rtl/qea_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature encoder accumulator - package
// Register map, reset values, field widths and the pin filter step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qea_pkg;

    localparam int COUNT_TOP_DEF = 65535;

    // Field widths fixed by the interface
    localparam int LEVEL_W  = 17;
    localparam int OFFSET_W = 17;
    localparam int FILT_W   = 4;
    localparam int GAIN_W   = 24;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;

    // Register indexes (byte address bit 2)
    localparam logic REG_FILTER_SAMPLES = 1'b0;
    localparam logic REG_STEP_GAIN      = 1'b1;

    localparam logic [FILT_W-1:0] FILTER_SAMPLES_RST = 4'd8;
    localparam logic [GAIN_W-1:0] STEP_GAIN_RST      = 24'd256;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic              lvl;
        logic [FILT_W-1:0] run;
        logic              moved;
    } t_filt;

    // One sample of the run-length filter on a single pin.
    function automatic t_filt f_pin_filter(
        input logic              raw,
        input logic              lvl,
        input logic [FILT_W-1:0] run,
        input logic [FILT_W-1:0] samples
    );
        t_filt             res;
        logic [FILT_W-1:0] need;
        logic [FILT_W-1:0] nxt;
        need      = (samples == '0) ? FILT_W'(1) : samples;
        nxt       = run + FILT_W'(1);
        res.lvl   = lvl;
        res.run   = '0;
        res.moved = 1'b0;
        if (raw != lvl) begin
            if (nxt >= need) begin
                res.lvl   = raw;
                res.moved = 1'b1;
            end else begin
                res.run = nxt;
            end
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/quadrature_encoder_accumulator.sv
// ----------------------------------------------------------------------------
// Quadrature encoder accumulator
// x4 quadrature decoder with pin filters and a clamped, gain-scaled level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one beat per item: i_mode = 0
//   is a sample tick of the raw pins i_pin_a / i_pin_b, i_mode = 1 is a read.
//   A tick filters both pins, decodes edges x4 and moves the wrapping
//   position counter; it gives no result beat. A read gives one result beat
//   on the output channel (o_valid / i_stall): o_count_offset is the
//   position minus its midpoint, o_level the new Q1.16 level after adding
//   offset * step_gain / 256 (rounded) and clamping to 0..1.0. The counter
//   then goes back to the midpoint.
//   Path: a read's beat waits in the input register until it fires, and
//   its result then loads into the result register; a full, stalled
//   result register holds the read in the input register.
//   One beat is taken per cycle while o_stall is low; the position and
//   level registers are updated as each beat fires.
//   Stall: a result waits in the output register; ticks keep flowing, and
//   only a read finding the output register full and stalled holds o_stall.
//   Reset (synchronous, active low) empties both registers, restores the
//   filter and gain registers and puts the counter at the midpoint.
//   Configuration is written over APB: filter_samples at 0x0, step_gain 0x4.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quadrature_encoder_accumulator_defines.svh"

module quadrature_encoder_accumulator
    import qea_pkg::*;
#(
    parameter int COUNT_TOP = COUNT_TOP_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Sample / read channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_mode,
    input  logic                       i_pin_a,
    input  logic                       i_pin_b,
    // Result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [LEVEL_W-1:0]         o_level,
    output logic signed [OFFSET_W-1:0] o_count_offset,
    // Configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    localparam int POS_W     = $clog2(COUNT_TOP + 1);
    localparam int COUNT_MID = COUNT_TOP / 2;
    localparam int PROD_W    = OFFSET_W + GAIN_W + 1;
    localparam int SUM_W     = PROD_W + 1;

    // Step the position counter by one with wrap over 0..COUNT_TOP.
    function automatic logic [POS_W-1:0] f_count_step(
        input logic [POS_W-1:0] pos,
        input logic             up
    );
        logic [POS_W-1:0] res;
        if (up) begin
            res = (pos >= POS_W'(COUNT_TOP)) ? '0 : pos + POS_W'(1);
        end else begin
            res = (pos == '0) ? POS_W'(COUNT_TOP) : pos - POS_W'(1);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FILT_W-1:0] r_filter_samples;
    logic [GAIN_W-1:0] r_step_gain;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_samples <= FILTER_SAMPLES_RST;
            r_step_gain      <= STEP_GAIN_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_FILTER_SAMPLES: r_filter_samples <= pwdata[FILT_W-1:0];
                REG_STEP_GAIN:      r_step_gain      <= pwdata[GAIN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FILTER_SAMPLES: prdata = DATA_W'(r_filter_samples);
            REG_STEP_GAIN:      prdata = DATA_W'(r_step_gain);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and handshake
    // ------------------------------------------------------------------
    logic r_in_valid;
    logic r_mode;
    logic r_pin_a;
    logic r_pin_b;
    logic r_out_valid;
    logic w_out_free;
    logic w_fire;
    logic w_fire_read;

    // A tick always completes; a read needs room in the result register.
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_fire      = r_in_valid && ((r_mode == MODE_TICK) || w_out_free);
    assign w_fire_read = w_fire && (r_mode == MODE_READ);
    assign o_stall     = r_in_valid && !w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    // Payload: load a new beat whenever the stage moves on
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_mode  <= i_mode;
            r_pin_a <= i_pin_a;
            r_pin_b <= i_pin_b;
        end
    end

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    logic              r_filt_a;
    logic              r_filt_b;
    logic [FILT_W-1:0] r_run_a;
    logic [FILT_W-1:0] r_run_b;
    logic [POS_W-1:0]  r_position;
    logic [LEVEL_W-1:0] r_accum;

    t_filt            w_fa;
    t_filt            w_fb;
    logic [POS_W-1:0] w_pos_a;
    logic [POS_W-1:0] w_pos_b;

    // Filter A first; B then sees the new filtered A
    always_comb begin
        w_fa    = f_pin_filter(r_pin_a, r_filt_a, r_run_a, r_filter_samples);
        w_fb    = f_pin_filter(r_pin_b, r_filt_b, r_run_b, r_filter_samples);
        w_pos_a = w_fa.moved ? f_count_step(r_position, w_fa.lvl != r_filt_b)
                             : r_position;
        w_pos_b = w_fb.moved ? f_count_step(w_pos_a, w_fb.lvl == w_fa.lvl)
                             : w_pos_a;
    end

    // ------------------------------------------------------------------
    // Read path: offset * gain, add to level, round and clamp
    // ------------------------------------------------------------------
    logic signed [OFFSET_W-1:0] w_offset;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [SUM_W-1:0]    w_sum;
    logic [SUM_W-9:0]           w_quot;
    logic [LEVEL_W-1:0]         n_level;

    always_comb begin
        w_offset = OFFSET_W'(r_position) - OFFSET_W'(COUNT_MID);
        w_prod   = PROD_W'(w_offset) * $signed({1'b0, r_step_gain});
        w_sum    = $signed({{(SUM_W - LEVEL_W - 8){1'b0}}, r_accum, 8'd0})
                 + SUM_W'(w_prod) + SUM_W'(128);
        w_quot   = w_sum[SUM_W-1:8];
        // Drop negatives to zero, saturate at 1.0
        if (w_sum < 0) begin
            n_level = '0;
        end else if (w_quot > (SUM_W-8)'(LEVEL_ONE)) begin
            n_level = LEVEL_ONE;
        end else begin
            n_level = w_quot[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_a   <= 1'b0;
            r_filt_b   <= 1'b0;
            r_run_a    <= '0;
            r_run_b    <= '0;
            r_position <= POS_W'(COUNT_MID);
            r_accum    <= '0;
        end else if (w_fire) begin
            if (r_mode == MODE_TICK) begin
                r_filt_a   <= w_fa.lvl;
                r_filt_b   <= w_fb.lvl;
                r_run_a    <= w_fa.run;
                r_run_b    <= w_fb.run;
                r_position <= w_pos_b;
            end else begin
                // Re-centre the counter after each read
                r_position <= POS_W'(COUNT_MID);
                r_accum    <= n_level;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0]         r_level;
    logic signed [OFFSET_W-1:0] r_count_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire_read) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire_read) begin
            r_level        <= n_level;
            r_count_offset <= w_offset;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_level        = r_level;
    assign o_count_offset = r_count_offset;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `QEA_ASSERT(a_pos_in_range, i_clk, i_rst_n, r_position <= POS_W'(COUNT_TOP))
    `QEA_ASSERT(a_level_clamped, i_clk, i_rst_n, r_accum <= LEVEL_ONE)
    `QEA_ASSERT(a_read_recentres, i_clk, i_rst_n,
        w_fire_read |=> (r_position == POS_W'(COUNT_MID)) && r_out_valid)
    `QEA_ASSERT_ALWAYS(a_stall_only_on_read, i_clk,
        o_stall |-> (r_in_valid && (r_mode == MODE_READ) && r_out_valid && i_stall))

endmodule
